>>> design/mvm_pkg.sv
// Shared constants and types for the matrix-vector multiply modulo block.
// No dependencies; imported by matrix_vector_multiply_mod.
package mvm_pkg;

  localparam int MVM_DIM_DEF = 3;
  localparam int SYM_W       = 8;
  localparam int MOD_W       = 9;
  localparam int KEY_W       = 32;
  localparam int KEY_ROWS    = 4;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [MOD_W-1:0] MOD_RESET = 9'd26;

  typedef enum logic [2:0] {
    REG_MODULUS = 3'd0,
    REG_KEY0    = 3'd1,
    REG_KEY1    = 3'd2,
    REG_KEY2    = 3'd3,
    REG_KEY3    = 3'd4
  } reg_idx_t;

endpackage

>>> design/matrix_vector_multiply_mod.sv
// Top level of the Hill-style block transform: APB register file, symbol
// collection, bit-serial row products and radix-4 serial modular reduction.
// Depends on mvm_pkg.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_ready  in_symbol_value
//   out_      output     out_valid/out_ready out_result_value, out_last_of_block
//   cfg (APB) input      psel/penable/pready paddr, pwdata, prdata
//
// A symbol that does not complete a block is stored in the collection buffer.
// After the last symbol of a block, each row passes through the bit-serial
// multiply (S_MUL), the serial reduction (S_RED) and the output register
// (S_OUT); no new symbol is taken until the last row has been loaded.
// Reset is synchronous and active low; no clearing pass is needed.
// A full output register holds the engine until the result is taken.
module matrix_vector_multiply_mod
  import mvm_pkg::*;
#(
  parameter int DIM = MVM_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SYM_W-1:0]   in_symbol_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SYM_W-1:0]   out_result_value,
  output logic               out_last_of_block,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int BUF_D     = (DIM > 1) ? DIM - 1 : 1;
  localparam int FILL_W    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ROW_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int T_W       = SYM_W + $clog2(DIM);
  localparam int SUM_W     = 2 * SYM_W + $clog2(DIM);
  localparam int RED_STEPS = (SUM_W + 1) / 2;
  localparam int RED_W     = 2 * RED_STEPS;
  localparam int STEP_W    = $clog2(SYM_W + RED_STEPS);
  localparam int R4_W      = MOD_W + 2;

  typedef enum logic [1:0] {
    S_COLLECT,
    S_MUL,
    S_RED,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SYM_W-1:0]    buf_r [BUF_D];
  logic [SYM_W-1:0]    buf_nxt [BUF_D];
  logic [SYM_W-1:0]    sym_sh_r [DIM];
  logic [SYM_W-1:0]    sym_sh_nxt [DIM];
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [RED_W-1:0]    red_sh_r, red_sh_nxt;
  logic [MOD_W-1:0]    rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]    out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;
  logic [MOD_W-1:0]    mod_r, mod_nxt;
  logic [KEY_W-1:0]    key0_r, key1_r, key2_r, key3_r;
  logic [KEY_W-1:0]    key0_nxt, key1_nxt, key2_nxt, key3_nxt;

  logic                cfg_we;
  reg_idx_t            cfg_idx;
  logic                in_acc;
  logic                out_load;
  logic                row_last;
  logic [KEY_W-1:0]    key_row;
  logic [T_W-1:0]      term;
  logic [R4_W-1:0]     r4, m1, m2, m3;

  assign cfg_we   = psel & penable & pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[4:2]);
  assign pready   = 1'b1;
  assign in_ready = (state_r == S_COLLECT);
  assign in_acc   = in_valid & in_ready;
  assign out_load = (state_r == S_OUT) & (~out_valid_r | out_ready);
  assign row_last = (row_r == ROW_W'(DIM - 1));

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_last_of_block = out_last_r;

  always_comb begin
    unique case (2'(row_r))
      2'd0:    key_row = key0_r;
      2'd1:    key_row = key1_r;
      2'd2:    key_row = key2_r;
      default: key_row = key3_r;
    endcase
  end

  always_comb begin
    case (cfg_idx)
      REG_MODULUS: prdata = PDATA_W'(mod_r);
      REG_KEY0:    prdata = key0_r;
      REG_KEY1:    prdata = key1_r;
      REG_KEY2:    prdata = key2_r;
      REG_KEY3:    prdata = key3_r;
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    term = '0;
    for (int j = 0; j < DIM; j++) begin
      if (sym_sh_r[j][SYM_W-1]) begin
        term = term + T_W'(key_row[8*j +: 8]);
      end
    end
  end

  assign r4 = {rem_r, red_sh_r[RED_W-1 -: 2]};
  assign m1 = R4_W'(mod_r);
  assign m2 = {1'b0, mod_r, 1'b0};
  assign m3 = m1 + m2;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    row_nxt       = row_r;
    step_nxt      = step_r;
    buf_nxt       = buf_r;
    sym_sh_nxt    = sym_sh_r;
    acc_nxt       = acc_r;
    red_sh_nxt    = red_sh_r;
    rem_nxt       = rem_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    mod_nxt       = mod_r;
    key0_nxt      = key0_r;
    key1_nxt      = key1_r;
    key2_nxt      = key2_r;
    key3_nxt      = key3_r;

    if (cfg_we) begin
      case (cfg_idx)
        REG_MODULUS: mod_nxt  = pwdata[MOD_W-1:0];
        REG_KEY0:    key0_nxt = pwdata;
        REG_KEY1:    key1_nxt = pwdata;
        REG_KEY2:    key2_nxt = pwdata;
        REG_KEY3:    key3_nxt = pwdata;
        default:     ;
      endcase
    end

    unique case (state_r)
      S_COLLECT: begin
        if (in_acc) begin
          if (fill_r == FILL_W'(DIM - 1)) begin
            for (int j = 0; j < DIM - 1; j++) begin
              sym_sh_nxt[j] = buf_r[j];
            end
            sym_sh_nxt[DIM-1] = in_symbol_value;
            fill_nxt  = '0;
            row_nxt   = '0;
            step_nxt  = '0;
            acc_nxt   = '0;
            state_nxt = S_MUL;
          end else begin
            for (int j = 0; j < BUF_D; j++) begin
              if (fill_r == FILL_W'(j)) begin
                buf_nxt[j] = in_symbol_value;
              end
            end
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      S_MUL: begin
        for (int j = 0; j < DIM; j++) begin
          sym_sh_nxt[j] = {sym_sh_r[j][SYM_W-2:0], sym_sh_r[j][SYM_W-1]};
        end
        acc_nxt = {acc_r[SUM_W-2:0], 1'b0} + SUM_W'(term);
        if (step_r == STEP_W'(SYM_W - 1)) begin
          red_sh_nxt = RED_W'(acc_nxt);
          rem_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = S_RED;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_RED: begin
        red_sh_nxt = {red_sh_r[RED_W-3:0], 2'b00};
        if (r4 >= m3) begin
          rem_nxt = MOD_W'(r4 - m3);
        end else if (r4 >= m2) begin
          rem_nxt = MOD_W'(r4 - m2);
        end else if (r4 >= m1) begin
          rem_nxt = MOD_W'(r4 - m1);
        end else begin
          rem_nxt = MOD_W'(r4);
        end
        if (step_r == STEP_W'(RED_STEPS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (mod_r == '0) ? acc_r[SYM_W-1:0] : rem_r[SYM_W-1:0];
          out_last_nxt  = row_last;
          step_nxt      = '0;
          acc_nxt       = '0;
          if (row_last) begin
            state_nxt = S_COLLECT;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      fill_r      <= '0;
      row_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_RESET;
      key0_r      <= '0;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      row_r       <= row_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      mod_r       <= mod_nxt;
      key0_r      <= key0_nxt;
      key1_r      <= key1_nxt;
      key2_r      <= key2_nxt;
      key3_r      <= key3_nxt;
    end
    buf_r       <= buf_nxt;
    sym_sh_r    <= sym_sh_nxt;
    acc_r       <= acc_nxt;
    red_sh_r    <= red_sh_nxt;
    rem_r       <= rem_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DIM - 1))
    else $error("Symbol fill count beyond block size.");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && fill_r == FILL_W'(DIM - 1)) |=> (state_r == S_MUL && row_r == '0))
    else $error("Completed block did not start the row products.");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED && mod_r != '0) |-> (rem_r < mod_r))
    else $error("Partial remainder not below modulus.");

  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && row_last) |=> (state_r == S_COLLECT && fill_r == '0 && out_last_r))
    else $error("Last row did not close the block.");

endmodule
